FILE: design/hsip_pkg.sv
// Shared types, constants and round functions for the HalfSipHash-1-3 stream unit.
// No dependencies; used by hsip_final.sv and halfsiphash_1_3_stream_unit.sv.
`timescale 1ns / 1ps

package hsip_pkg;

    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
    } t_sip_state;

    localparam logic [31:0] SIP_C2        = 32'h6c796765;
    localparam logic [31:0] SIP_C3        = 32'h74656462;
    localparam logic [31:0] SIP_FINAL_XOR = 32'h000000ff;

    localparam logic [31:0] KEY_LOW_RESET  = 32'h01020304;
    localparam logic [31:0] KEY_HIGH_RESET = 32'hfffefdfc;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 8'd1;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        rotl32 = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_sip_state sip_round(input t_sip_state s);
        t_sip_state r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl32(r.v1, 5'd5);
        r.v1 = r.v1 ^ r.v0;
        r.v0 = rotl32(r.v0, 5'd16);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl32(r.v3, 5'd8);
        r.v3 = r.v3 ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl32(r.v3, 5'd7);
        r.v3 = r.v3 ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl32(r.v1, 5'd13);
        r.v1 = r.v1 ^ r.v2;
        r.v2 = rotl32(r.v2, 5'd16);
        sip_round = r;
    endfunction

    function automatic t_sip_state sip_absorb(input t_sip_state s, input logic [31:0] m);
        t_sip_state r;
        r = s;
        r.v3 = r.v3 ^ m;
        r = sip_round(r);
        r.v0 = r.v0 ^ m;
        sip_absorb = r;
    endfunction

endpackage

FILE: design/hsip_final.sv
// Finalization pipeline: absorbs the closing word, then three rounds, one per stage.
// Depends on hsip_pkg (state type and round functions).
`timescale 1ns / 1ps

module hsip_final (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  hsip_pkg::t_sip_state    i_state,
    input  logic [31:0]             i_word,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [31:0]             o_hash
);

    logic                 r_vld0, r_vld1, r_vld2, r_vld3, r_out_vld;
    hsip_pkg::t_sip_state r_st0, r_st1, r_st2, r_st3;
    logic [31:0]          r_word;
    logic [31:0]          r_hash;
    logic                 rdy0, rdy1, rdy2, rdy3, rdy_out;
    hsip_pkg::t_sip_state n_st1, n_last;

    // Each stage may take new data when it is empty or its successor moves.
    assign rdy_out = !r_out_vld || i_ready;
    assign rdy3    = !r_vld3 || rdy_out;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign rdy0    = !r_vld0 || rdy1;

    always_comb begin
        n_st1    = hsip_pkg::sip_absorb(r_st0, r_word);
        n_st1.v2 = n_st1.v2 ^ hsip_pkg::SIP_FINAL_XOR;
        n_last   = hsip_pkg::sip_round(r_st3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0    <= 1'b0;
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy0)    r_vld0    <= i_valid;
            if (rdy1)    r_vld1    <= r_vld0;
            if (rdy2)    r_vld2    <= r_vld1;
            if (rdy3)    r_vld3    <= r_vld2;
            if (rdy_out) r_out_vld <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_st0  <= i_state;
            r_word <= i_word;
        end
        if (rdy1)    r_st1  <= n_st1;
        if (rdy2)    r_st2  <= hsip_pkg::sip_round(r_st1);
        if (rdy3)    r_st3  <= hsip_pkg::sip_round(r_st2);
        if (rdy_out) r_hash <= n_last.v1 ^ n_last.v3;
    end

    assign o_ready = rdy0;
    assign o_valid = r_out_vld;
    assign o_hash  = r_hash;

endmodule

FILE: design/halfsiphash_1_3_stream_unit.sv
// HalfSipHash-1-3 over a byte stream: one byte per transaction, one hash per message.
// The last transaction of a message gives its hash once it has passed the finalization pipeline.
// One transaction is accepted every cycle unless a held-off output has backed up the
// finalization pipeline; the per-word round runs in a single feedback stage on the
// v registers, and finalization is a 5-register pipeline.
// Reset loads the key registers with their defaults and empties the pipeline.
// Depends on hsip_pkg and hsip_final.
`timescale 1ns / 1ps

module halfsiphash_1_3_stream_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_byte_present,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [31:0]                          o_hash_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hsip_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    logic [31:0]          r_key_low, r_key_high;
    hsip_pkg::t_sip_state r_v;
    logic [31:0]          r_acc;
    logic [1:0]           r_lane;
    logic [7:0]           r_len;
    logic                 r_in_msg;

    hsip_pkg::t_sip_state v_base, n_v;
    logic [31:0]          acc_base, acc_p, n_acc;
    logic [1:0]           lane_base, n_lane;
    logic [7:0]           len_base, n_len;
    logic [31:0]          byte_word;
    logic                 word_full;
    logic                 accept;
    logic                 fin_ready;

    assign accept      = i_valid && fin_ready;
    assign o_ready     = fin_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        // The first transaction of a message starts from the keys.
        if (r_in_msg) begin
            v_base    = r_v;
            acc_base  = r_acc;
            lane_base = r_lane;
            len_base  = r_len;
        end else begin
            v_base.v0 = r_key_low;
            v_base.v1 = r_key_high;
            v_base.v2 = r_key_low ^ hsip_pkg::SIP_C2;
            v_base.v3 = r_key_high ^ hsip_pkg::SIP_C3;
            acc_base  = '0;
            lane_base = '0;
            len_base  = '0;
        end

        unique case (lane_base)
            2'd0:    byte_word = {24'd0, i_data_byte};
            2'd1:    byte_word = {16'd0, i_data_byte, 8'd0};
            2'd2:    byte_word = {8'd0, i_data_byte, 16'd0};
            default: byte_word = {i_data_byte, 24'd0};
        endcase

        if (i_byte_present) begin
            acc_p     = acc_base | byte_word;
            n_lane    = lane_base + 2'd1;
            n_len     = len_base + 8'd1;
            word_full = (lane_base == 2'd3);
        end else begin
            acc_p     = acc_base;
            n_lane    = lane_base;
            n_len     = len_base;
            word_full = 1'b0;
        end

        if (word_full) begin
            n_v   = hsip_pkg::sip_absorb(v_base, acc_p);
            n_acc = '0;
        end else begin
            n_v   = v_base;
            n_acc = acc_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= hsip_pkg::KEY_LOW_RESET;
            r_key_high <= hsip_pkg::KEY_HIGH_RESET;
            r_in_msg   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == hsip_pkg::CFG_KEY_LOW)  r_key_low  <= i_cfg_data;
                if (i_cfg_index == hsip_pkg::CFG_KEY_HIGH) r_key_high <= i_cfg_data;
            end
            if (accept) r_in_msg <= !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v    <= n_v;
            r_acc  <= n_acc;
            r_lane <= n_lane;
            r_len  <= n_len;
        end
    end

    hsip_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept && i_last),
        .o_ready (fin_ready),
        .i_state (n_v),
        .i_word  (n_acc | {n_len, 24'd0}),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hash  (o_hash_value)
    );

endmodule

FILE: tb/hsip_checker.sv
// Checker for the HalfSipHash-1-3 stream unit: watches the byte, hash and key-write channels,
// predicts each message hash and compares it with what the unit returns.
// Depends on hsip_pkg for the state type, the constants and the register indexes.
`timescale 1ns / 1ps

module hsip_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_byte_present,
    input  logic                             i_last,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [31:0]                      o_hash_value,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  logic [hsip_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending_hashes
);

    logic [31:0]          key_low_q;
    logic [31:0]          key_high_q;
    hsip_pkg::t_sip_state sip;
    logic [31:0]          word_acc;
    logic [1:0]           lane;
    logic [7:0]           msg_len;
    logic                 in_msg;
    logic [31:0]          expected_hashes[$];
    logic [31:0]          want;
    int                   fail_total = 0;
    int                   pending_now = 0;

    assign o_fail_count     = fail_total;
    assign o_pending_hashes = pending_now;

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} << n;
        return twice[63:32];
    endfunction

    function automatic hsip_pkg::t_sip_state half_round(input hsip_pkg::t_sip_state s);
        logic [31:0] a, b, c, d;
        a = s.v0;
        b = s.v1;
        c = s.v2;
        d = s.v3;
        a = a + b;
        b = rot_left(b, 5) ^ a;
        a = rot_left(a, 16);
        c = c + d;
        d = rot_left(d, 8) ^ c;
        a = a + d;
        d = rot_left(d, 7) ^ a;
        c = c + b;
        b = rot_left(b, 13) ^ c;
        c = rot_left(c, 16);
        return '{v0: a, v1: b, v2: c, v3: d};
    endfunction

    function automatic hsip_pkg::t_sip_state absorb_word(input hsip_pkg::t_sip_state s,
                                                         input logic [31:0] m);
        hsip_pkg::t_sip_state r;
        r = s;
        r.v3 = r.v3 ^ m;
        r = half_round(r);
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_low_q  = hsip_pkg::KEY_LOW_RESET;
            key_high_q = hsip_pkg::KEY_HIGH_RESET;
            sip        = '0;
            word_acc   = '0;
            lane       = '0;
            msg_len    = '0;
            in_msg     = 1'b0;
            expected_hashes.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: no transaction pending, expected none, got %h",
                           o_hash_value);
                    fail_total++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_hash_value !== want) begin
                        $error("hash_value mismatch: expected %h, got %h", want, o_hash_value);
                        fail_total++;
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == hsip_pkg::CFG_KEY_LOW)
                    key_low_q = i_cfg_data;
                else if (i_cfg_index == hsip_pkg::CFG_KEY_HIGH)
                    key_high_q = i_cfg_data;
            end

            if (i_valid && o_ready) begin
                // Any first transaction of a message, idle ones included, reloads from the keys.
                if (!in_msg) begin
                    sip      = '{v0: key_low_q, v1: key_high_q,
                                 v2: key_low_q ^ hsip_pkg::SIP_C2,
                                 v3: key_high_q ^ hsip_pkg::SIP_C3};
                    word_acc = '0;
                    lane     = '0;
                    msg_len  = '0;
                    in_msg   = 1'b1;
                end
                if (i_byte_present) begin
                    word_acc[8*lane +: 8] = i_data_byte;
                    lane    = lane + 2'd1;
                    msg_len = msg_len + 8'd1;
                    if (lane == 2'd0) begin
                        sip      = absorb_word(sip, word_acc);
                        word_acc = '0;
                    end
                end
                if (i_last) begin
                    sip    = absorb_word(sip, word_acc | {msg_len, 24'h000000});
                    sip.v2 = sip.v2 ^ hsip_pkg::SIP_FINAL_XOR;
                    sip    = half_round(half_round(half_round(sip)));
                    expected_hashes.push_back(sip.v1 ^ sip.v3);
                    word_acc = '0;
                    lane     = '0;
                    msg_len  = '0;
                    in_msg   = 1'b0;
                end
            end
        end
        pending_now = expected_hashes.size();
    end

endmodule

FILE: tb/tb.sv
// Top of the testbench: clock, reset, byte-stream and key-write stimulus, output back-pressure
// and the verdict. Instantiates halfsiphash_1_3_stream_unit and hsip_checker; uses hsip_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 150;
    localparam int PHASE_ITEMS   = 150;
    localparam int IDX_W         = hsip_pkg::CFG_INDEX_W;
    localparam logic [IDX_W-1:0] CFG_FIRST_UNUSED = hsip_pkg::CFG_KEY_HIGH + 1'b1;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_data_byte;
    logic              i_byte_present;
    logic              i_last;
    logic              o_valid;
    logic              i_ready;
    logic [31:0]       o_hash_value;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [31:0]       i_cfg_data;

    int       fail_count;
    int       pending_hashes;
    int       hold_request = 0;
    int       counted_items = 0;
    int       burst_left = 0;
    int       phase_end;
    int       stall_len;
    int       stretch;
    t_rx_mode rx_mode;

    halfsiphash_1_3_stream_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hash_value   (o_hash_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    hsip_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_hash_value     (o_hash_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending_hashes (pending_hashes)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: stretches of different stall patterns, plus a long hold-off on request.
    initial begin
        forever begin
            if (hold_request != 0) begin
                stall_len    = hold_request;
                hold_request = 0;
                i_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end else begin
                stretch = $urandom_range(8, 64);
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                for (int k = 0; k < stretch; k++) begin
                    case (rx_mode)
                        RX_ALWAYS:   i_ready <= 1'b1;
                        RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
                        default:     i_ready <= (k % 3 == 2);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    // Handshakes are sampled at the falling edge, where everything has settled.
    task automatic send_item(input logic [7:0] d, input logic p, input logic l);
        int  gap;
        logic rdy;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if (p || l)
            counted_items++;
        i_valid        <= 1'b1;
        i_data_byte    <= d;
        i_byte_present <= p;
        i_last         <= l;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // A message of random bytes with some idle transactions mixed in. It ends either on
    // its final byte or with a bare end marker; an empty message is the marker alone.
    task automatic send_message(input int nbytes);
        logic bare_end;
        bare_end = (nbytes == 0) || ($urandom_range(0, 2) == 0);
        for (int k = 0; k < nbytes; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !bare_end && (k == nbytes - 1));
        end
        if (bare_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic write_key(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        logic rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // Both keys, then a write to an index past the register list, which must be ignored.
    task automatic program_keys(input logic [31:0] lo, input logic [31:0] hi);
        write_key(hsip_pkg::CFG_KEY_LOW, lo);
        write_key(hsip_pkg::CFG_KEY_HIGH, hi);
        write_key(IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << IDX_W) - 1)),
                  $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every outstanding hash, then let the pipeline settle.
    task automatic wait_idle;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_hashes != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_data_byte    <= '0;
        i_byte_present <= 1'b0;
        i_last         <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the reset keys: empty message, single zero byte,
        // a word-aligned message ended on its byte and one ended by a bare marker.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        repeat (3) send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hfe, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        // An idle transaction opens the message, another one sits inside it.
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        wait_idle;
        program_keys(32'h00000000, 32'h00000000);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        wait_idle;
        program_keys(32'hffffffff, 32'hffffffff);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // Keys changed in the middle of a message apply only from the next message on.
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        wait_idle;
        program_keys($urandom, $urandom);
        send_item(8'h56, 1'b1, 1'b1);
        send_item(8'h78, 1'b1, 1'b1);

        counted_items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle;
            case (phase)
                1:       program_keys(32'h00000000, 32'hffffffff);
                2:       program_keys(32'hffffffff, 32'h00000000);
                4:       program_keys(hsip_pkg::KEY_LOW_RESET, hsip_pkg::KEY_HIGH_RESET);
                default: program_keys($urandom, $urandom);
            endcase
            phase_end = counted_items + PHASE_ITEMS;
            if (phase == 2) begin
                // Keep offering short messages while the output is held off, so the
                // unit fills up and has to stall its input.
                hold_request = LONG_HOLD;
                repeat (40) send_message(1);
            end
            if (phase == 3)
                send_message($urandom_range(256, 300));
            while (counted_items < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: send_message($urandom_range(0, 8));
                    6, 7, 8:          send_message($urandom_range(9, 40));
                    default:          send_message($urandom_range(41, 80));
                endcase
            end
        end

        wait_idle;
        if (fail_count == 0 && pending_hashes == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/hsip_pkg.sv
design/hsip_final.sv
design/halfsiphash_1_3_stream_unit.sv
tb/hsip_checker.sv
tb/tb.sv
